>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both macros expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/dmsc_pkg.sv
package dmsc_pkg;

	localparam int NUM_KW = 10;

	// Parser phases.
	localparam logic [1:0] PH_START        = 2'd0;
	localparam logic [1:0] PH_AFTER_DOLLAR = 2'd1;
	localparam logic [1:0] PH_IN_KW        = 2'd2;
	localparam logic [1:0] PH_AFTER_KW     = 2'd3;

	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	// Keyword text, first character in byte 0. The literals are written
	// reversed so that the first character lands in the lowest byte.
	localparam logic [15:0][7:0] KW_TEXT [NUM_KW] = '{
		128'("yna"),       // any
		128'("shm"),       // mhs
		128'("lacisyhp"),  // physical
		128'("xelet"),     // telex
		128'("xetelet"),   // teletex
		128'("enohpelet"), // telephone
		128'("xaf3g"),     // g3fax
		128'("xaf4g"),     // g4fax
		128'("5ai"),       // ia5
		128'("xetoediv")   // videotex
	};

	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd3, 4'd3, 4'd8, 4'd5, 4'd7, 4'd9, 4'd5, 4'd5, 4'd3, 4'd8
	};

	typedef struct packed {
		logic [1:0]        phase;
		logic [NUM_KW-1:0] cand;
		logic [3:0]        pos;
		logic              failed;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:  PH_START,
		cand:   '0,
		pos:    4'd0,
		failed: 1'b0
	};

endpackage

>>> hw/rtl/dmsc_step.sv
// Next-state logic of the parser for one byte.
module dmsc_step (
	input  dmsc_pkg::state_t cur,
	input  logic [7:0]       byte_value,
	output dmsc_pkg::state_t nxt,
	output logic             completed
);

	logic [7:0]                   c_fold;
	logic                         in_kw;
	logic [dmsc_pkg::NUM_KW-1:0]  mask;
	logic [3:0]                   pos_base;
	logic [3:0]                   pos_inc;
	logic [dmsc_pkg::NUM_KW-1:0]  hit;
	logic [dmsc_pkg::NUM_KW-1:0]  len_eq;
	logic                         done;

	// Only ASCII A to Z fold to lower case.
	assign c_fold = (byte_value >= dmsc_pkg::CH_UPPER_A && byte_value <= dmsc_pkg::CH_UPPER_Z)
		? byte_value + dmsc_pkg::CASE_DELTA : byte_value;

	// A new term starts with every keyword as a candidate at position zero.
	assign in_kw    = (cur.phase == dmsc_pkg::PH_IN_KW);
	assign mask     = in_kw ? cur.cand : '1;
	assign pos_base = in_kw ? cur.pos : 4'd0;
	assign pos_inc  = pos_base + 4'd1;

	always_comb begin
		for (int k = 0; k < dmsc_pkg::NUM_KW; k++) begin
			hit[k] = mask[k] && (pos_base < dmsc_pkg::KW_LEN[k])
				&& (dmsc_pkg::KW_TEXT[k][pos_base] == c_fold);
			len_eq[k] = (dmsc_pkg::KW_LEN[k] == pos_inc);
		end
	end

	assign done = |(hit & len_eq);

	always_comb begin
		nxt       = cur;
		completed = 1'b0;
		if (!cur.failed) begin
			unique case (cur.phase) inside
				dmsc_pkg::PH_START, dmsc_pkg::PH_IN_KW, dmsc_pkg::PH_AFTER_DOLLAR: begin
					if (cur.phase != dmsc_pkg::PH_AFTER_DOLLAR || c_fold != dmsc_pkg::CH_SPACE) begin
						if (hit == '0) begin
							nxt.failed = 1'b1;
							nxt.pos    = pos_base;
						end else begin
							nxt.cand  = hit;
							nxt.pos   = pos_inc;
							nxt.phase = done ? dmsc_pkg::PH_AFTER_KW : dmsc_pkg::PH_IN_KW;
							completed = done;
						end
					end
				end
				default: begin
					if (c_fold == dmsc_pkg::CH_DOLLAR) begin
						nxt.phase = dmsc_pkg::PH_AFTER_DOLLAR;
					end else if (c_fold != dmsc_pkg::CH_SPACE) begin
						nxt.failed = 1'b1;
					end
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/delivery_method_syntax_check.sv
// Channel | Direction | Signals                           | Content
// s       | in        | s_tvalid s_tready s_tdata s_tlast | one byte, tlast on final byte
// m       | out       | m_tvalid m_tready m_tdata         | one verdict per value, bit 0 = invalid
//
// Each byte is registered at the input, parsed by a single layer of logic in
// the following cycle, and a new byte can be taken every cycle unless stalled.
// The verdict is registered at the edge where the final byte leaves the input
// register, and m_tvalid goes high with it; an untaken verdict can delay that edge.
// Only a final byte waits on the output register; other bytes keep flowing while
// a verdict is still pending, so a stalled m side holds up at most one byte.
// arst_n clears the input valid, the parser state and the output valid at once.
`include "assert_macros.svh"

module delivery_method_syntax_check (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] byte_value
	input  logic       s_tlast,   // last_byte

	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] invalid, [7:1] zero
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state and its next value.
	dmsc_pkg::state_t st_q;
	dmsc_pkg::state_t st_nxt;
	logic             completed;

	// Output register.
	logic out_valid_q;
	logic invalid_q;

	logic advance;
	logic verdict;

	// A byte moves out of the input stage unless it is a final byte and the
	// output register still holds an untaken verdict.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	dmsc_step u_step (
		.cur        (st_q),
		.byte_value (byte_s1),
		.nxt        (st_nxt),
		.completed  (completed)
	);

	// The value is valid only if a keyword was completed by its final byte.
	assign verdict = st_nxt.failed || !completed;

	// The parser returns to its start state after every final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dmsc_pkg::STATE_RESET;
		end else if (advance) begin
			st_q <= last_s1 ? dmsc_pkg::STATE_RESET : st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			invalid_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, invalid_q};

	`ASSERT_NEXT(a_verdict_follows_last, advance && last_s1, m_tvalid,
		"no verdict after a final byte")
	`ASSERT_NEXT(a_state_cleared, advance && last_s1, st_q == dmsc_pkg::STATE_RESET,
		"parser state not cleared after a final byte")
	`ASSERT_NEXT(a_failed_sticky, st_q.failed && !(advance && last_s1), st_q.failed,
		"failure flag dropped within a value")
	`ASSERT_ALWAYS(a_cand_nonzero, st_q.phase != dmsc_pkg::PH_IN_KW || st_q.cand != '0,
		"inside a keyword with no candidate left")

endmodule

>>> sim/delivery_method_syntax_check_tb.sv
module delivery_method_syntax_check_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// A value that is checked against the predictor rather than a typed verdict.
	localparam int FROM_PREDICTOR = -1;
	// Length of the single long receiver hold-off, in cycles.
	localparam int HOLD_CYCLES = 400;
	// Cycles without any transaction before the run is declared hung.
	localparam int QUIET_LIMIT = 4000;
	// Input bytes per random phase; with the directed values and the hold-off
	// values this gives roughly 1250 bytes in all.
	localparam int PHASE_BYTES = 270;
	// Cycles allowed after the last verdict for any stray output to show up.
	localparam int TAIL_CYCLES = 10;

	// Ways a well-formed keyword list gets broken in the random part.
	typedef enum int {
		FLIP_BYTE,
		CUT_SHORT,
		ADD_SPACE,
		ADD_DOLLAR,
		LEAD_SPACE,
		PUT_TAB
	} damage_t;

	localparam logic [7:0] CH_TAB = 8'h09;

	typedef struct {
		string      text;    // empty means the value is the single byte in raw
		logic [7:0] raw;
		int         verdict; // typed invalid flag, or FROM_PREDICTOR
	} directed_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	delivery_method_syntax_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Keyword spellings for the predictor, in the order of the candidate bits.
	string kw_word [dmsc_pkg::NUM_KW] = '{
		"any", "mhs", "physical", "telex", "teletex",
		"telephone", "g3fax", "g4fax", "ia5", "videotex"
	};

	// Predictor state, initialised at start and cleared after every final byte.
	logic [1:0]                  ps_phase  = dmsc_pkg::PH_START;
	logic [dmsc_pkg::NUM_KW-1:0] ps_cand   = '0;
	logic [3:0]                  ps_pos    = '0;
	logic                        ps_failed = 1'b0;

	// Verdicts still owed by the block, oldest first.
	logic pending_verdicts [$];
	int   error_count = 0;

	// Idle and stall rates in percent, changed per phase by the stimulus.
	int send_idle_pct = 0;
	int stall_pct = 0;

	// The verdict typed in the directed table travels alongside the byte.
	int typed_verdict = FROM_PREDICTOR;

	// Hold-off request from the stimulus and its acknowledge from the receiver.
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int   hold_left = 0;

	// Both handshakes and the data that goes with them are sampled at the falling
	// edge, where every signal has settled, and are then used at the next rising
	// edge. This keeps the checking free of any ordering within the rising edge.
	logic       s_take = 1'b0;
	logic       m_take = 1'b0;
	logic [7:0] s_byte_smp = 8'h00;
	logic       s_last_smp = 1'b0;
	int         s_typed_smp = FROM_PREDICTOR;
	logic [7:0] m_byte_smp = 8'h00;

	always @(negedge clk) begin
		s_take = arst_n && s_tvalid && s_tready;
		m_take = arst_n && m_tvalid && m_tready;
		s_byte_smp = s_tdata;
		s_last_smp = s_tlast;
		s_typed_smp = typed_verdict;
		m_byte_smp = m_tdata;
	end

	// Runs one accepted byte through the predictor. On a final byte it hands back
	// the verdict and clears the state for the next value.
	task automatic parse_byte(input logic [7:0] raw, input logic fin, output logic emit,
			output logic bad);
		logic [7:0]                  c;
		logic [dmsc_pkg::NUM_KW-1:0] mask;
		logic [dmsc_pkg::NUM_KW-1:0] hits;
		logic                        try_match;
		logic                        ends_kw;
		c = raw;
		if (c >= dmsc_pkg::CH_UPPER_A && c <= dmsc_pkg::CH_UPPER_Z) begin
			c = c + dmsc_pkg::CASE_DELTA;
		end
		try_match = 1'b0;
		ends_kw = 1'b0;
		mask = ps_cand;
		if (!ps_failed) begin
			case (ps_phase) inside
				dmsc_pkg::PH_START, dmsc_pkg::PH_AFTER_DOLLAR: begin
					// Spaces are skipped only after a separator; at the very start
					// a space goes to the matcher and fails there.
					if (ps_phase == dmsc_pkg::PH_START || c != dmsc_pkg::CH_SPACE) begin
						ps_pos = '0;
						mask = '1;
						try_match = 1'b1;
					end
				end
				dmsc_pkg::PH_IN_KW: try_match = 1'b1;
				default: begin
					if (c == dmsc_pkg::CH_DOLLAR) begin
						ps_phase = dmsc_pkg::PH_AFTER_DOLLAR;
					end else if (c != dmsc_pkg::CH_SPACE) begin
						ps_failed = 1'b1;
					end
				end
			endcase
		end
		if (try_match) begin
			hits = '0;
			for (int k = 0; k < dmsc_pkg::NUM_KW; k++) begin
				if (mask[k] && ps_pos < kw_word[k].len() && kw_word[k][ps_pos] == c) begin
					hits[k] = 1'b1;
				end
			end
			if (hits == '0) begin
				ps_failed = 1'b1;
			end else begin
				ps_pos = ps_pos + 4'd1;
				for (int k = 0; k < dmsc_pkg::NUM_KW; k++) begin
					if (hits[k] && kw_word[k].len() == ps_pos) begin
						ends_kw = 1'b1;
					end
				end
				ps_cand = hits;
				ps_phase = ends_kw ? dmsc_pkg::PH_AFTER_KW : dmsc_pkg::PH_IN_KW;
			end
		end
		// Only a keyword finished on this very byte makes a value valid.
		emit = fin;
		bad = ps_failed || !ends_kw;
		if (fin) begin
			ps_phase = dmsc_pkg::PH_START;
			ps_cand = '0;
			ps_pos = '0;
			ps_failed = 1'b0;
		end
	endtask

	// Scoreboard: predict on every accepted byte, check every accepted verdict.
	always @(posedge clk) begin : scoreboard
		logic emit;
		logic bad;
		logic want;
		if (s_take) begin
			parse_byte(s_byte_smp, s_last_smp, emit, bad);
			if (emit) begin
				pending_verdicts.push_back(s_typed_smp == FROM_PREDICTOR ? bad : s_typed_smp[0]);
			end
		end
		if (m_take) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict with no value pending: invalid=%0b", m_byte_smp[0]);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (m_byte_smp[0] !== want) begin
					$error("invalid: expected %0b, got %0b", want, m_byte_smp[0]);
					error_count++;
				end
			end
		end
	end

	// Receiver. Normally it stalls at the rate of the current phase; once, on
	// request, it holds off for a long stretch counted here, so that verdicts
	// back up and the block has to stop taking bytes.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_ack) begin
			hold_ack <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: a long run of cycles with no transaction on either side means a hang.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || s_take || m_take) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("delivery_method_syntax_check_tb: done, errors");
			$finish;
		end
	end

	// Offers the bytes of one value, the last one marked, with random idle gaps
	// before each byte. Each byte is held until its transaction completes.
	task automatic send_value(input logic [7:0] bytes [$], input int verdict);
		for (int i = 0; i < bytes.size(); i++) begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= bytes[i];
			s_tlast <= (i == bytes.size() - 1);
			typed_verdict <= verdict;
			@(posedge clk);
			while (!s_take) begin
				@(posedge clk);
			end
		end
	endtask

	// Builds one random value. Most are keyword lists with random letter case and
	// random spaces around the separators; some of those are then damaged in one
	// spot, and a few values are plain noise bytes.
	task automatic make_value(ref logic [7:0] bytes [$]);
		int         roll;
		int         idx;
		string      word;
		logic [7:0] ch;
		bytes.delete();
		roll = $urandom_range(99);
		if (roll < 15) begin
			repeat ($urandom_range(1, 6)) begin
				bytes.push_back(8'($urandom_range(255)));
			end
		end else begin
			repeat ($urandom_range(1, 4)) begin
				if (bytes.size() != 0) begin
					repeat ($urandom_range(0, 2)) bytes.push_back(dmsc_pkg::CH_SPACE);
					bytes.push_back(dmsc_pkg::CH_DOLLAR);
					repeat ($urandom_range(0, 2)) bytes.push_back(dmsc_pkg::CH_SPACE);
				end
				word = kw_word[$urandom_range(dmsc_pkg::NUM_KW - 1)];
				for (int j = 0; j < word.len(); j++) begin
					ch = word[j];
					if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(1)) begin
						ch = ch - dmsc_pkg::CASE_DELTA;
					end
					bytes.push_back(ch);
				end
			end
			if (roll >= 70) begin
				idx = $urandom_range(bytes.size() - 1);
				case (damage_t'($urandom_range(PUT_TAB)))
					FLIP_BYTE: bytes[idx] = 8'($urandom_range(255));
					CUT_SHORT: bytes = bytes[0:idx];
					ADD_SPACE: bytes.push_back(dmsc_pkg::CH_SPACE);
					ADD_DOLLAR: bytes.push_back(dmsc_pkg::CH_DOLLAR);
					LEAD_SPACE: bytes.push_front(dmsc_pkg::CH_SPACE);
					default: bytes.insert(idx, CH_TAB);
				endcase
			end
		end
	endtask

	// Directed values: valid lists, folded case, and several ways a value goes wrong,
	// with the extreme byte values on their own.
	directed_row_t directed [] = '{
		'{"any",      8'h00, 0},
		'{"G3FAX",    8'h00, 0},
		'{"mhs$ ia5", 8'h00, FROM_PREDICTOR},
		'{" any",     8'h00, 1},               // leading space, rest ignored
		'{"an",       8'h00, 1},               // term too short
		'{"any$",     8'h00, 1},               // trailing separator
		'{"ia5 ",     8'h00, 1},               // trailing space
		'{"",         8'h00, 1},               // lowest byte alone
		'{"",         8'hFF, 1}                // highest byte alone
	};

	initial begin : stimulus
		logic [7:0] bytes [$];
		int         sent;
		int         phase_idle [4];
		int         phase_stall [4];
		phase_idle = '{0, 69, 0, 18};
		phase_stall = '{0, 0, 69, 18};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r]) begin
			bytes.delete();
			if (directed[r].text.len() == 0) begin
				bytes.push_back(directed[r].raw);
			end else begin
				for (int i = 0; i < directed[r].text.len(); i++) begin
					bytes.push_back(directed[r].text[i]);
				end
			end
			send_value(bytes, directed[r].verdict);
		end

		// Long receiver hold-off while the sender keeps offering values back to back.
		hold_req <= 1'b1;
		while (!hold_ack) begin
			@(posedge clk);
		end
		repeat (8) begin
			make_value(bytes);
			send_value(bytes, FROM_PREDICTOR);
		end

		// Random values through the idle and stall phases, including a phase with none.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct <= phase_idle[p];
			stall_pct <= phase_stall[p];
			sent = 0;
			while (sent < PHASE_BYTES) begin
				make_value(bytes);
				send_value(bytes, FROM_PREDICTOR);
				sent += bytes.size();
			end
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$error("%0d verdicts never arrived", pending_verdicts.size());
			error_count++;
		end

		if (error_count == 0) begin
			$display("delivery_method_syntax_check_tb: done, clean");
		end else begin
			$display("delivery_method_syntax_check_tb: done, errors");
		end
		$finish;
	end

endmodule
